@@ src/gep_pkg.sv @@
// Package for the gamma encoder: word types, channel classes and the root table.
package gep_pkg;

	// Q0.30 fraction steps in the log and the power units
	localparam int FRAC_STEPS = 30;
	// Register stages in each unit
	localparam int LOG_STAGES = FRAC_STEPS + 1;
	localparam int POW_STAGES = FRAC_STEPS + 2;
	localparam int PIPE_STAGES = LOG_STAGES + POW_STAGES;

	localparam logic [15:0] GAMMA_RESET = 16'd7447;
	localparam logic [7:0] BYTE_FULL = 8'hFF;

	// Channel class, decided at entry
	typedef enum logic [1:0] {
		CLS_NORM = 2'd0,
		CLS_ZERO = 2'd1,
		CLS_FULL = 2'd2
	} chan_cls_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [19:0] red_linear;
		logic [19:0] green_linear;
		logic [19:0] blue_linear;
	} pix_in_t;

	typedef struct packed {
		logic [11:0] out_x;
		logic [11:0] out_y;
		logic [7:0]  red_byte;
		logic [7:0]  green_byte;
		logic [7:0]  blue_byte;
		logic [7:0]  alpha_byte;
	} pix_out_t;

	// Floor square root of a 64-bit constant
	function automatic logic [63:0] isqrt64(logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bt;
		n = n_in;
		res = 64'd0;
		bt = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (bt > n) bt = bt >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (bt != 64'd0) begin
				if (n >= res + bt) begin
					n = n - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

	// 2^(-2^-idx) in Q32, idx 1..30, clamped below 1.0
	function automatic logic [31:0] root_q32(int idx);
		logic [63:0] r;
		r = isqrt64(64'd1 << 63);
		for (int i = 2; i <= FRAC_STEPS; i++) begin
			if (i <= idx) r = isqrt64(r << 32);
		end
		if (r >= (64'd1 << 32)) r = (64'd1 << 32) - 64'd1;
		return r[31:0];
	endfunction

endpackage

@@ src/gep_log2.sv @@
// Pipelined fractional log2 of one channel by repeated squaring.
module gep_log2
	import gep_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [19:0]       x,
	output logic [29:0]       frac,
	output logic [3:0]        msb,
	output chan_cls_t         cls
);

	logic [30:0] m_s    [0:FRAC_STEPS];
	logic [29:0] frac_s [0:FRAC_STEPS];
	logic [3:0]  msb_s  [0:FRAC_STEPS];
	chan_cls_t   cls_s  [0:FRAC_STEPS];

	logic [3:0]  p;
	logic [30:0] m_norm;
	chan_cls_t   cls_in;

	// top set bit and normalized mantissa in Q1.30
	always_comb begin
		p = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) p = 4'(i);
		end
		m_norm = 31'(x[15:0]) << (5'd30 - 5'(p));
		if (x[19:16] != 4'd0) cls_in = CLS_FULL;
		else if (x[15:0] == 16'd0) cls_in = CLS_ZERO;
		else cls_in = CLS_NORM;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= m_norm;
			frac_s[0] <= 30'd0;
			msb_s[0]  <= p;
			cls_s[0]  <= cls_in;
		end
	end

	// one squaring step per stage, one fraction bit each
	for (genvar g = 0; g < FRAC_STEPS; g++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] s;
		assign sq = 62'(m_s[g]) * 62'(m_s[g]);
		assign s  = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g+1]    <= s[31] ? s[31:1] : s[30:0];
				frac_s[g+1] <= frac_s[g] | (s[31] ? (30'd1 << (FRAC_STEPS - 1 - g)) : 30'd0);
				msb_s[g+1]  <= msb_s[g];
				cls_s[g+1]  <= cls_s[g];
			end
		end
	end

	assign frac = frac_s[FRAC_STEPS];
	assign msb  = msb_s[FRAC_STEPS];
	assign cls  = cls_s[FRAC_STEPS];

endmodule

@@ src/gep_pow.sv @@
// Pipelined scale by the exponent, exp2 by root products, and byte conversion.
module gep_pow
	import gep_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] gamma_e,
	input  logic [29:0] frac,
	input  logic [3:0]  msb,
	input  chan_cls_t   cls,
	output logic [7:0]  byte_out
);

	logic [32:0] y_s   [0:FRAC_STEPS];
	logic [29:0] f_s   [0:FRAC_STEPS];
	logic [6:0]  k_s   [0:FRAC_STEPS];
	chan_cls_t   cls_s [0:FRAC_STEPS];
	logic [7:0]  byte_q;

	logic [34:0] n_log;
	logic [50:0] prod;
	chan_cls_t   cls_e;

	// negated log in Q30 times the exponent
	always_comb begin
		n_log = (35'(5'd16 - 5'(msb)) << 30) - 35'(frac);
		prod  = 51'(n_log) * 51'(gamma_e);
		cls_e = (gamma_e == 16'd0) ? CLS_FULL : cls;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s[0]   <= 33'd1 << 32;
			f_s[0]   <= prod[43:14];
			k_s[0]   <= prod[50:44];
			cls_s[0] <= cls_e;
		end
	end

	// one root factor per stage for each set fraction bit
	for (genvar g = 0; g < FRAC_STEPS; g++) begin : g_root
		localparam logic [31:0] ROOT = root_q32(g + 1);
		logic [64:0] yp;
		assign yp = 65'(y_s[g]) * 65'(ROOT);
		always_ff @(posedge clk) begin
			if (en) begin
				y_s[g+1]   <= f_s[g][FRAC_STEPS - 1 - g] ? yp[64:32] : y_s[g];
				f_s[g+1]   <= f_s[g];
				k_s[g+1]   <= k_s[g];
				cls_s[g+1] <= cls_s[g];
			end
		end
	end

	logic [32:0] y_sh;
	logic [40:0] y255;
	logic [7:0]  b_norm;

	// integer part shift, then scale by 255
	always_comb begin
		y_sh = (k_s[FRAC_STEPS] >= 7'd40) ? 33'd0 : (y_s[FRAC_STEPS] >> k_s[FRAC_STEPS]);
		y255 = (41'(y_sh) << 8) - 41'(y_sh);
		b_norm = (y255[40:32] > 9'd255) ? BYTE_FULL : y255[39:32];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (cls_s[FRAC_STEPS])
				CLS_FULL: byte_q <= BYTE_FULL;
				CLS_ZERO: byte_q <= 8'd0;
				default:  byte_q <= b_norm;
			endcase
		end
	end

	assign byte_out = byte_q;

endmodule

@@ src/gamma_encode_pixel_top.sv @@
// Gamma encoder top level: input skid, three channel pipelines and coordinate delay.
// Encodes one linear RGB pixel (Q4.16 per channel) to 8-bit channels as
// 255*x^e with e the inverse_gamma register (Q2.14), via exp2(e*log2(x)).
// One pixel per clock unless the output stalls; the pipeline has one squaring
// stage per log bit (30), one root-multiply stage per fraction bit (30), and
// three stages for normalize, scale and byte. A stall at the output freezes
// the whole pipeline; a one-word input skid takes one word. inverse_gamma resets
// to 1/2.2; the user must write it only while idle; the block does not enforce it.
module gamma_encode_pixel_top
	import gep_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  pix_in_t     in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output pix_out_t    out_word
);

	localparam logic [11:0] CMASK = 12'((32'd1 << COORD_BITS) - 32'd1);

	logic [15:0] gamma_q;
	logic        skid_full_q;
	pix_in_t     skid_q;
	pix_in_t     src;
	logic        src_valid;
	logic        en;

	logic [PIPE_STAGES-1:0] v_q;
	logic [11:0] x_q [0:PIPE_STAGES-1];
	logic [11:0] y_q [0:PIPE_STAGES-1];

	// whole pipeline advances unless a waiting word is held
	assign en        = !(v_q[PIPE_STAGES-1] && out_stall);
	assign in_stall  = skid_full_q;
	assign src       = skid_full_q ? skid_q : in_word;
	assign src_valid = skid_full_q || in_valid;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gamma_q <= GAMMA_RESET;
		else if (cfg_we) gamma_q <= cfg_data;
	end

	// input skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skid_full_q <= 1'b0;
		else skid_full_q <= en ? 1'b0 : (skid_full_q || in_valid);
	end

	always_ff @(posedge clk) begin
		if (!en && !skid_full_q && in_valid) skid_q <= in_word;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[PIPE_STAGES-2:0], src_valid};
	end

	// coordinate delay line
	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= src.pixel_x & CMASK;
			y_q[0] <= src.pixel_y & CMASK;
			for (int i = 1; i < PIPE_STAGES; i++) begin
				x_q[i] <= x_q[i-1];
				y_q[i] <= y_q[i-1];
			end
		end
	end

	// three channel pipelines
	logic [19:0] lin   [0:2];
	logic [7:0]  bytes [0:2];

	assign lin[0] = src.red_linear;
	assign lin[1] = src.green_linear;
	assign lin[2] = src.blue_linear;

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [29:0] frac;
		logic [3:0]  msb;
		chan_cls_t   cls;
		gep_log2 u_log (
			.clk  (clk),
			.en   (en),
			.x    (lin[c]),
			.frac (frac),
			.msb  (msb),
			.cls  (cls)
		);
		gep_pow u_pow (
			.clk      (clk),
			.en       (en),
			.gamma_e  (gamma_q),
			.frac     (frac),
			.msb      (msb),
			.cls      (cls),
			.byte_out (bytes[c])
		);
	end

	assign out_valid           = v_q[PIPE_STAGES-1];
	assign out_word.out_x      = x_q[PIPE_STAGES-1];
	assign out_word.out_y      = y_q[PIPE_STAGES-1];
	assign out_word.red_byte   = bytes[0];
	assign out_word.green_byte = bytes[1];
	assign out_word.blue_byte  = bytes[2];
	assign out_word.alpha_byte = BYTE_FULL;

	// skid drains as soon as the pipeline moves
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && en) |=> !skid_full_q)
		else $error("skid not drained");

	// a held output word keeps the pipeline frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_word.out_x)))
		else $error("output moved under stall");

	// skid only fills while the pipeline is frozen
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(!en && in_valid))
		else $error("skid filled while moving");

endmodule
